>>> rtl/pdu_pkg.sv
`timescale 1ns / 1ps
// Package for the PSO dimension update block: widths, constants, types.
// No dependencies; used by every module under rtl/.
package pdu_pkg;

  localparam int FRAC_BITS = 16;

  localparam int POS_W = 24;
  localparam int MU_W  = 17;
  localparam int LF_W  = 20;
  localparam int BND_W = 23;
  localparam int DLT_W = 16;
  localparam int IDX_W = 8;

  localparam int NSTG = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam int S_TDATA_W = 136;
  localparam int M_TDATA_W = 64;

  localparam int M_VEL_LSB = POS_W;
  localparam int M_IDX_LSB = 2 * POS_W;
  localparam int M_CLP_BIT = 2 * POS_W + IDX_W;

  localparam logic [LF_W-1:0]  LF_RST    = LF_W'(131072);
  localparam logic [BND_W-1:0] STEP_RST  = BND_W'(65536);
  localparam logic [BND_W-1:0] IMIN_RST  = BND_W'(32768);
  localparam logic [BND_W-1:0] IMAX_RST  = BND_W'(524288);
  localparam logic [DLT_W-1:0] DELTA_RST = DLT_W'(32768);

  localparam logic [BND_W-1:0] FRAC_MASK = BND_W'((64'd1 << FRAC_BITS) - 64'd1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTR_GAIN    = 3'd0,
    REG_MAX_STEP     = 3'd1,
    REG_INTERVAL_MIN = 3'd2,
    REG_INTERVAL_MAX = 3'd3,
    REG_ROUND_THR    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [LF_W-1:0]  attr_gain;
    logic [BND_W-1:0] max_step;
    logic [BND_W-1:0] interval_min;
    logic [BND_W-1:0] interval_max;
    logic [DLT_W-1:0] round_thr;
  } cfg_t;

  typedef struct packed {
    logic [NSTG-1:0] en;
  } pipe_ctrl_t;

endpackage

>>> rtl/pdu_pipe_ctrl.sv
`timescale 1ns / 1ps
// Valid bits and per-stage load enables of the six-stage pipeline.
// Depends on pdu_pkg.
module pdu_pipe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output pdu_pkg::pipe_ctrl_t ctrl_o
);

  logic [pdu_pkg::NSTG-1:0] valid_q, valid_d;
  logic [pdu_pkg::NSTG-1:0] en;

  // a stage loads when empty or when the next one loads
  always_comb begin
    en[pdu_pkg::NSTG-1] = ~valid_q[pdu_pkg::NSTG-1] | out_ready_i;
    for (int k = pdu_pkg::NSTG - 2; k >= 0; k--) begin
      en[k] = ~valid_q[k] | en[k+1];
    end
    valid_d = valid_q;
    if (en[0]) valid_d[0] = in_valid_i;
    for (int k = 1; k < pdu_pkg::NSTG; k++) begin
      if (en[k]) valid_d[k] = valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[pdu_pkg::NSTG-1];
  assign ctrl_o.en   = en;

endmodule

>>> rtl/pdu_pos_path.sv
`timescale 1ns / 1ps
// Position path: step limit, bound clamp, state index encoding, delay to output.
// Depends on pdu_pkg.
module pdu_pos_path (
  input  logic                              clk_i,
  input  pdu_pkg::pipe_ctrl_t               ctrl_i,
  input  pdu_pkg::cfg_t                     cfg_i,
  input  logic signed [pdu_pkg::POS_W-1:0]  position_i,
  input  logic signed [pdu_pkg::POS_W-1:0]  velocity_i,
  output logic                              clamped_s4_o,
  output logic signed [pdu_pkg::POS_W-1:0]  new_position_o,
  output logic        [pdu_pkg::IDX_W-1:0]  state_index_o,
  output logic                              was_clamped_o
);

  localparam int NP_W  = pdu_pkg::POS_W + 2;
  localparam int CMP_W = pdu_pkg::FRAC_BITS + pdu_pkg::DLT_W;
  localparam int IW    = pdu_pkg::BND_W + 1;

  // stage 0: step-limited move
  logic signed [pdu_pkg::POS_W:0] vel_x, mag;
  logic signed [NP_W-1:0]         step_x;
  logic signed [NP_W-1:0]         np_d, np_q;

  always_comb begin
    vel_x  = (pdu_pkg::POS_W+1)'(velocity_i);
    mag    = vel_x[pdu_pkg::POS_W] ? -vel_x : vel_x;
    step_x = $signed({3'b000, cfg_i.max_step});
    if ($unsigned(mag) > {2'b00, cfg_i.max_step}) begin
      np_d = NP_W'(position_i) + (velocity_i[pdu_pkg::POS_W-1] ? -step_x : step_x);
    end else begin
      np_d = NP_W'(position_i) + NP_W'(velocity_i);
    end
  end

  // stage 1: lower bound first, then upper bound
  logic signed [NP_W-1:0]        imin_x, imax_x, v1;
  logic                          lowc, highc;
  logic [pdu_pkg::BND_W-1:0]     npc_d, npc_q;
  logic                          clp_d, clp_q;

  always_comb begin
    imin_x = $signed({3'b000, cfg_i.interval_min});
    imax_x = $signed({3'b000, cfg_i.interval_max});
    lowc   = np_q < imin_x;
    v1     = lowc ? imin_x : np_q;
    highc  = v1 > imax_x;
    npc_d  = highc ? cfg_i.interval_max : v1[pdu_pkg::BND_W-1:0];
    clp_d  = lowc | highc;
  end

  // stage 2: encoding
  logic [pdu_pkg::BND_W-1:0] ip;
  logic [CMP_W-1:0]          fr_sh, dl_sh;
  logic [IW-1:0]             idx_w;
  logic [pdu_pkg::IDX_W-1:0] idx_d, idx_q;
  logic [pdu_pkg::BND_W-1:0] npe_q;
  logic                      clpe_q;

  always_comb begin
    ip    = npc_q >> pdu_pkg::FRAC_BITS;
    fr_sh = CMP_W'(npc_q & pdu_pkg::FRAC_MASK) << pdu_pkg::DLT_W;
    dl_sh = CMP_W'(cfg_i.round_thr) << pdu_pkg::FRAC_BITS;
    idx_w = IW'(ip) + IW'(fr_sh >= dl_sh);
    if (idx_w > IW'(255)) begin
      idx_d = pdu_pkg::IDX_W'(255);
    end else begin
      idx_d = idx_w[pdu_pkg::IDX_W-1:0];
    end
  end

  // stages 3 to 5: align with the velocity path
  logic [pdu_pkg::BND_W-1:0] np3_q, np4_q, np5_q;
  logic [pdu_pkg::IDX_W-1:0] ix3_q, ix4_q, ix5_q;
  logic                      cl3_q, cl4_q, cl5_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) np_q <= np_d;
    if (ctrl_i.en[1]) begin
      npc_q <= npc_d;
      clp_q <= clp_d;
    end
    if (ctrl_i.en[2]) begin
      npe_q  <= npc_q;
      idx_q  <= idx_d;
      clpe_q <= clp_q;
    end
    if (ctrl_i.en[3]) begin
      np3_q <= npe_q;
      ix3_q <= idx_q;
      cl3_q <= clpe_q;
    end
    if (ctrl_i.en[4]) begin
      np4_q <= np3_q;
      ix4_q <= ix3_q;
      cl4_q <= cl3_q;
    end
    if (ctrl_i.en[5]) begin
      np5_q <= np4_q;
      ix5_q <= ix4_q;
      cl5_q <= cl4_q;
    end
  end

  assign clamped_s4_o   = cl4_q;
  assign new_position_o = $signed({1'b0, np5_q});
  assign state_index_o  = ix5_q;
  assign was_clamped_o  = cl5_q;

endmodule

>>> rtl/pdu_vel_path.sv
`timescale 1ns / 1ps
// Velocity path: attraction products, split gain multiply, rounding, saturation, zeroing when clamped.
// Depends on pdu_pkg.
module pdu_vel_path (
  input  logic                              clk_i,
  input  pdu_pkg::pipe_ctrl_t               ctrl_i,
  input  logic [pdu_pkg::LF_W-1:0]          attr_gain_i,
  input  logic signed [pdu_pkg::POS_W-1:0]  position_i,
  input  logic signed [pdu_pkg::POS_W-1:0]  velocity_i,
  input  logic signed [pdu_pkg::POS_W-1:0]  personal_best_i,
  input  logic signed [pdu_pkg::POS_W-1:0]  local_best_i,
  input  logic [pdu_pkg::MU_W-1:0]          mu_personal_i,
  input  logic [pdu_pkg::MU_W-1:0]          mu_local_i,
  input  logic                              clamped_i,
  output logic signed [pdu_pkg::POS_W-1:0]  new_velocity_o
);

  localparam int DW   = pdu_pkg::POS_W + 1;
  localparam int PW   = DW + pdu_pkg::MU_W + 1;
  localparam int SW   = PW + 1;
  localparam int LO_W = 22;
  localparam int HI_W = SW - LO_W;
  localparam int PLW  = LO_W + pdu_pkg::LF_W;
  localparam int PHW  = HI_W + pdu_pkg::LF_W + 1;
  localparam int AW   = 66;
  localparam int QW   = AW - 32;
  localparam int NW   = QW + 1;

  localparam logic signed [AW-1:0] RND  = AW'(64'sd2147483648);
  localparam logic signed [NW-1:0] VMAX = NW'(64'sd8388607);
  localparam logic signed [NW-1:0] VMIN = NW'(-64'sd8388608);

  logic signed [pdu_pkg::POS_W-1:0] v0_q, v1_q, v2_q, v3_q, v4_q;
  logic signed [DW-1:0]             d_q, e_q;
  logic [pdu_pkg::MU_W-1:0]         mu1_q, mu2_q;
  logic signed [PW-1:0]             p1_d, p2_d, p1_q, p2_q;
  logic signed [SW-1:0]             s_q;
  logic signed [HI_W-1:0]           hi;
  logic [LO_W-1:0]                  lo;
  logic signed [PHW-1:0]            phi_d, phi_q;
  logic [PLW-1:0]                   plo_d, plo_q;
  logic signed [AW-1:0]             acc;
  logic signed [QW-1:0]             q_q;
  logic signed [NW-1:0]             nsum;
  logic signed [pdu_pkg::POS_W-1:0] nv_d, nv_q;

  always_comb begin
    p1_d  = d_q * $signed({1'b0, mu1_q});
    p2_d  = e_q * $signed({1'b0, mu2_q});
    lo    = s_q[LO_W-1:0];
    hi    = s_q[SW-1:LO_W];
    phi_d = hi * $signed({1'b0, attr_gain_i});
    plo_d = lo * attr_gain_i;
    acc   = (AW'(phi_q) <<< LO_W) + $signed({{(AW-PLW){1'b0}}, plo_q}) + RND;
    nsum  = NW'(v4_q) + NW'(q_q);
    if (clamped_i) begin
      nv_d = '0;
    end else if (nsum > VMAX) begin
      nv_d = VMAX[pdu_pkg::POS_W-1:0];
    end else if (nsum < VMIN) begin
      nv_d = VMIN[pdu_pkg::POS_W-1:0];
    end else begin
      nv_d = nsum[pdu_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      d_q   <= DW'(personal_best_i) - DW'(position_i);
      e_q   <= DW'(local_best_i) - DW'(position_i);
      mu1_q <= mu_personal_i;
      mu2_q <= mu_local_i;
      v0_q  <= velocity_i;
    end
    if (ctrl_i.en[1]) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      v1_q <= v0_q;
    end
    if (ctrl_i.en[2]) begin
      s_q  <= SW'(p1_q) + SW'(p2_q);
      v2_q <= v1_q;
    end
    if (ctrl_i.en[3]) begin
      phi_q <= phi_d;
      plo_q <= plo_d;
      v3_q  <= v2_q;
    end
    if (ctrl_i.en[4]) begin
      q_q  <= $signed(acc[AW-1:32]);
      v4_q <= v3_q;
    end
    if (ctrl_i.en[5]) nv_q <= nv_d;
  end

  assign new_velocity_o = nv_q;

endmodule

>>> rtl/pso_dimension_update.sv
`timescale 1ns / 1ps
// PSO dimension update top level. An accepted input word passes through the six
// pipeline stages to the result word on m_axis; one word per cycle while m_axis
// does not stall. The pipeline depth follows the split 44x20 gain multiply.
// Reset: pipeline emptied, config registers at their reset values. cfg port always ready.
// Depends on pdu_pkg, pdu_pipe_ctrl, pdu_pos_path, pdu_vel_path.
module pso_dimension_update (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // position, velocity, personal_best, local_best, mu_personal, mu_local, pad
  input  logic [pdu_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // new_position, new_velocity, state_index, was_clamped, pad
  output logic [pdu_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pdu_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pdu_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  pdu_pkg::cfg_t       cfg_q, cfg_d;
  pdu_pkg::pipe_ctrl_t ctrl;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (pdu_pkg::reg_idx_e'(cfg_index_i))
        pdu_pkg::REG_ATTR_GAIN:
          cfg_d.attr_gain = cfg_data_i[pdu_pkg::LF_W-1:0];
        pdu_pkg::REG_MAX_STEP:       cfg_d.max_step     = cfg_data_i;
        pdu_pkg::REG_INTERVAL_MIN:   cfg_d.interval_min = cfg_data_i;
        pdu_pkg::REG_INTERVAL_MAX:   cfg_d.interval_max = cfg_data_i;
        pdu_pkg::REG_ROUND_THR:
          cfg_d.round_thr = cfg_data_i[pdu_pkg::DLT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attr_gain    <= pdu_pkg::LF_RST;
      cfg_q.max_step     <= pdu_pkg::STEP_RST;
      cfg_q.interval_min <= pdu_pkg::IMIN_RST;
      cfg_q.interval_max <= pdu_pkg::IMAX_RST;
      cfg_q.round_thr    <= pdu_pkg::DELTA_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  logic signed [pdu_pkg::POS_W-1:0] position, velocity, personal_best, local_best;
  logic [pdu_pkg::MU_W-1:0]         mu_personal, mu_local;

  assign position      = $signed(s_axis_tdata[23:0]);
  assign velocity      = $signed(s_axis_tdata[47:24]);
  assign personal_best = $signed(s_axis_tdata[71:48]);
  assign local_best    = $signed(s_axis_tdata[95:72]);
  assign mu_personal   = s_axis_tdata[112:96];
  assign mu_local      = s_axis_tdata[129:113];

  pdu_pipe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .ctrl_o     (ctrl)
  );

  logic                             clamped_s4;
  logic signed [pdu_pkg::POS_W-1:0] new_position, new_velocity;
  logic [pdu_pkg::IDX_W-1:0]        state_index;
  logic                             was_clamped;

  pdu_pos_path u_pos (
    .clk_i         (clk_i),
    .ctrl_i        (ctrl),
    .cfg_i         (cfg_q),
    .position_i    (position),
    .velocity_i    (velocity),
    .clamped_s4_o  (clamped_s4),
    .new_position_o(new_position),
    .state_index_o (state_index),
    .was_clamped_o (was_clamped)
  );

  pdu_vel_path u_vel (
    .clk_i          (clk_i),
    .ctrl_i         (ctrl),
    .attr_gain_i    (cfg_q.attr_gain),
    .position_i     (position),
    .velocity_i     (velocity),
    .personal_best_i(personal_best),
    .local_best_i   (local_best),
    .mu_personal_i  (mu_personal),
    .mu_local_i     (mu_local),
    .clamped_i      (clamped_s4),
    .new_velocity_o (new_velocity)
  );

  assign m_axis_tdata = {7'd0, was_clamped, state_index, new_velocity, new_position};

endmodule

>>> rtl/pdu_checker.sv
`timescale 1ns / 1ps
// Port-level checks for pso_dimension_update, bound to the top level.
// Depends on pdu_pkg.
module pdu_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pdu_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic [pdu_pkg::IDX_W-1:0] int_part;
  assign int_part = m_axis_tdata[pdu_pkg::FRAC_BITS +: pdu_pkg::IDX_W];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_clamp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[pdu_pkg::M_CLP_BIT]
      |-> m_axis_tdata[pdu_pkg::M_VEL_LSB +: pdu_pkg::POS_W] == '0)
    else $error("clamped result with non-zero velocity");

  a_pos_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[pdu_pkg::POS_W-1])
    else $error("negative position after clamp");

  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[pdu_pkg::M_IDX_LSB +: pdu_pkg::IDX_W] == int_part) ||
      (m_axis_tdata[pdu_pkg::M_IDX_LSB +: pdu_pkg::IDX_W] == int_part + 8'd1))
    else $error("state index does not match position");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind pso_dimension_update pdu_checker u_pdu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
